[src/bfsh_pkg.sv]
// Shared types and constants for the single-hash Bloom filter.
// Used by bfsh_ctrl, bfsh_dpath and bloom_filter_single_hash; depends on nothing.
package bfsh_pkg;

	// Default size of the filter word store
	localparam int WORDS_DEFAULT = 1024;

	// Field and register widths
	localparam int KEY_W      = 32;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 11;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 40;
	localparam logic [CFG_W-1:0] NUM_WORDS_RST = 11'd1024;

	// Hash word split: upper bits select the word, low bits select the bit
	localparam int BIT_W      = 5;
	localparam int DVD_W      = 27;
	localparam int DIV_CNT_W  = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd27;

	// 32-bit MurmurHash3 constants
	localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2    = 32'h1b873593;
	localparam logic [31:0] MUR_N     = 32'he6546b64;
	localparam logic [31:0] MUR_LEN   = 32'h00000004;
	localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
	localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;

	// Operation codes carried on s_tuser
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_K1,
		ST_MUL_K2,
		ST_BODY,
		ST_MUL_F1,
		ST_MUL_F2,
		ST_FIN,
		ST_DIV,
		ST_READ,
		ST_RESP
	} state_t;

	// Hash register operations
	typedef enum logic [2:0] {
		HOP_NONE,
		HOP_LOAD,
		HOP_MUL_K1,
		HOP_MUL_K2,
		HOP_BODY,
		HOP_MUL_F1,
		HOP_MUL_F2,
		HOP_FIN
	} hash_op_t;

	// Commands from controller to datapath
	typedef struct packed {
		hash_op_t hash_op;
		logic     clr_step;
		logic     div_step;
		logic     mem_read;
		logic     commit;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

[src/bfsh_ctrl.sv]
// Controller state machine of the Bloom filter: sequences clear, hash,
// division, memory read and result commit. Depends on bfsh_pkg.
module bfsh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bfsh_pkg::status_t status,
	output bfsh_pkg::cmd_t    cmd
);

	bfsh_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bfsh_pkg::ST_CLEAR: begin
				if (status.clr_last) state_nxt = bfsh_pkg::ST_IDLE;
			end
			bfsh_pkg::ST_IDLE: begin
				if (s_tvalid) state_nxt = bfsh_pkg::ST_MUL_K1;
			end
			bfsh_pkg::ST_MUL_K1: state_nxt = bfsh_pkg::ST_MUL_K2;
			bfsh_pkg::ST_MUL_K2: state_nxt = bfsh_pkg::ST_BODY;
			bfsh_pkg::ST_BODY:   state_nxt = bfsh_pkg::ST_MUL_F1;
			bfsh_pkg::ST_MUL_F1: state_nxt = bfsh_pkg::ST_MUL_F2;
			bfsh_pkg::ST_MUL_F2: state_nxt = bfsh_pkg::ST_FIN;
			bfsh_pkg::ST_FIN:    state_nxt = bfsh_pkg::ST_DIV;
			bfsh_pkg::ST_DIV: begin
				if (status.div_last) state_nxt = bfsh_pkg::ST_READ;
			end
			bfsh_pkg::ST_READ:   state_nxt = bfsh_pkg::ST_RESP;
			bfsh_pkg::ST_RESP: begin
				if (status.out_free) state_nxt = bfsh_pkg::ST_IDLE;
			end
			default:             state_nxt = bfsh_pkg::ST_CLEAR;
		endcase
	end

	// Command outputs
	always_comb begin
		s_tready     = 1'b0;
		cmd.hash_op  = bfsh_pkg::HOP_NONE;
		cmd.clr_step = 1'b0;
		cmd.div_step = 1'b0;
		cmd.mem_read = 1'b0;
		cmd.commit   = 1'b0;
		unique case (state_q)
			bfsh_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
			bfsh_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd.hash_op = bfsh_pkg::HOP_LOAD;
			end
			bfsh_pkg::ST_MUL_K1: cmd.hash_op = bfsh_pkg::HOP_MUL_K1;
			bfsh_pkg::ST_MUL_K2: cmd.hash_op = bfsh_pkg::HOP_MUL_K2;
			bfsh_pkg::ST_BODY:   cmd.hash_op = bfsh_pkg::HOP_BODY;
			bfsh_pkg::ST_MUL_F1: cmd.hash_op = bfsh_pkg::HOP_MUL_F1;
			bfsh_pkg::ST_MUL_F2: cmd.hash_op = bfsh_pkg::HOP_MUL_F2;
			bfsh_pkg::ST_FIN:    cmd.hash_op = bfsh_pkg::HOP_FIN;
			bfsh_pkg::ST_DIV:    cmd.div_step = 1'b1;
			bfsh_pkg::ST_READ:   cmd.mem_read = 1'b1;
			bfsh_pkg::ST_RESP:   cmd.commit = status.out_free;
			default: ;
		endcase
	end

endmodule

[src/bfsh_dpath.sv]
// Datapath of the Bloom filter: hash register with shared multiplier,
// restoring divider, filter word memory, insert counter, output register.
// Depends on bfsh_pkg; driven by bfsh_ctrl.
module bfsh_dpath #(
	parameter int WORDS = bfsh_pkg::WORDS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bfsh_pkg::cmd_t                  cmd,
	output bfsh_pkg::status_t               status,
	input  logic [bfsh_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bfsh_pkg::CFG_W-1:0]      cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bfsh_pkg::M_DATA_W-1:0]   m_tdata
);

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int NW = $clog2(WORDS + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

	logic [31:0]                       hash_q;
	logic                              func_q;
	logic [bfsh_pkg::DVD_W-1:0]        dvd_q;
	logic [bfsh_pkg::BIT_W-1:0]        bit_q;
	logic [NW-1:0]                     rem_q;
	logic [bfsh_pkg::DIV_CNT_W-1:0]    div_cnt_q;
	logic [AW-1:0]                     clr_addr_q;
	logic [bfsh_pkg::CFG_W-1:0]        num_words_q;
	logic [bfsh_pkg::CNT_W-1:0]        count_q;
	logic [31:0]                       rd_q;
	logic                              m_tvalid_q;
	logic                              present_q;
	logic [bfsh_pkg::CNT_W-1:0]        m_count_q;
	logic [31:0]                       mem [WORDS];

	logic [31:0]   mul_a, mul_b, prod;
	logic [31:0]   body_rot, body_sum, body_x, f2_x, fin_x;
	logic [31:0]   n_ext;
	logic [NW-1:0] n_eff;
	logic [NW:0]   trial, trial_sub;
	logic [AW-1:0] idx;
	logic [31:0]   new_word;
	logic [bfsh_pkg::CNT_W-1:0] count_nxt;
	logic          present_nxt;

	// Configuration: always ready; the word count must stay put while an item is in flight
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_words_q <= bfsh_pkg::NUM_WORDS_RST;
		end else if (cfg_valid) begin
			num_words_q <= cfg_data;
		end
	end

	// Clamp the configured word count to 1..WORDS
	always_comb begin
		n_ext = 32'(num_words_q);
		if (n_ext == 32'd0) begin
			n_eff = NW'(1);
		end else if (n_ext > 32'(WORDS)) begin
			n_eff = NW'(WORDS);
		end else begin
			n_eff = n_ext[NW-1:0];
		end
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = hash_q;
		mul_b = bfsh_pkg::MUR_C1;
		f2_x  = hash_q ^ (hash_q >> 13);
		case (cmd.hash_op)
			bfsh_pkg::HOP_MUL_K2: begin
				mul_a = {hash_q[16:0], hash_q[31:17]};
				mul_b = bfsh_pkg::MUR_C2;
			end
			bfsh_pkg::HOP_MUL_F1: mul_b = bfsh_pkg::MUR_F1;
			bfsh_pkg::HOP_MUL_F2: begin
				mul_a = f2_x;
				mul_b = bfsh_pkg::MUR_F2;
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// Body mix: rotate, times five plus constant, length, first fold
	assign body_rot = {hash_q[18:0], hash_q[31:19]};
	assign body_sum = (body_rot << 2) + body_rot + bfsh_pkg::MUR_N;
	assign body_x   = body_sum ^ bfsh_pkg::MUR_LEN;
	assign fin_x    = hash_q ^ (hash_q >> 16);

	// Hash register
	always_ff @(posedge clk) begin
		case (cmd.hash_op)
			bfsh_pkg::HOP_LOAD: begin
				hash_q <= s_tdata;
				func_q <= s_tuser;
			end
			bfsh_pkg::HOP_MUL_K1,
			bfsh_pkg::HOP_MUL_K2,
			bfsh_pkg::HOP_MUL_F1,
			bfsh_pkg::HOP_MUL_F2: hash_q <= prod;
			bfsh_pkg::HOP_BODY:   hash_q <= body_x ^ (body_x >> 16);
			default: ;
		endcase
	end

	// Restoring divider: one quotient bit per step, remainder is the word index
	assign trial     = {rem_q, dvd_q[bfsh_pkg::DVD_W-1]};
	assign trial_sub = trial - {1'b0, n_eff};

	always_ff @(posedge clk) begin
		if (cmd.hash_op == bfsh_pkg::HOP_FIN) begin
			dvd_q     <= fin_x[31:bfsh_pkg::BIT_W];
			bit_q     <= fin_x[bfsh_pkg::BIT_W-1:0];
			rem_q     <= '0;
			div_cnt_q <= bfsh_pkg::DIV_STEPS;
		end else if (cmd.div_step) begin
			dvd_q     <= {dvd_q[bfsh_pkg::DVD_W-2:0], 1'b0};
			rem_q     <= (trial >= {1'b0, n_eff}) ? trial_sub[NW-1:0] : trial[NW-1:0];
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	assign idx = rem_q[AW-1:0];

	// Clear sweep address after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step && clr_addr_q != LAST_ADDR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Merge the hashed bit and form the result
	assign new_word    = rd_q | (32'd1 << bit_q);
	assign count_nxt   = (func_q == bfsh_pkg::FUNC_INSERT) ? count_q + 1'b1 : count_q;
	assign present_nxt = (func_q == bfsh_pkg::FUNC_QUERY) ? rd_q[bit_q] : 1'b0;

	// Filter word memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.commit && func_q == bfsh_pkg::FUNC_INSERT) begin
			mem[idx] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			rd_q <= mem[idx];
		end
	end

	// Insert counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	// Output register: load on commit, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			present_q <= present_nxt;
			m_count_q <= count_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(bfsh_pkg::M_DATA_W - bfsh_pkg::CNT_W - 1){1'b0}}, m_count_q, present_q};

	// Status back to the controller
	assign status.clr_last = (clr_addr_q == LAST_ADDR);
	assign status.div_last = (div_cnt_q == bfsh_pkg::DIV_CNT_W'(1));
	assign status.out_free = !m_tvalid_q || m_tready;

endmodule

[src/bloom_filter_single_hash.sv]
// Top level of the single-hash Bloom filter: joins controller and datapath.
// Depends on bfsh_pkg, bfsh_ctrl and bfsh_dpath.
//
//  channel | signals                          | payload
//  --------+----------------------------------+---------------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser| tdata: key[31:0]; tuser: func
//  m_      | m_tvalid m_tready m_tdata        | tdata: present[0], insert_count[32:1]
//  cfg_    | cfg_valid cfg_ready cfg_data     | num_words[10:0]
//
// From acceptance to the next acceptance, when the output is free, an item passes
// through six hash steps, four of them through the one shared 32x32 multiplier,
// 27 steps of the restoring divider that maps the hash to a word, one memory read,
// one commit and the idle state that accepts the next item.
// After reset a clearing pass zeroes every word of the store, with s_tready low.
// A stalled result waits in the output register; the commit of the next one waits
// until that register is taken. Configuration is accepted every cycle.
module bloom_filter_single_hash #(
	parameter int WORDS = bfsh_pkg::WORDS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bfsh_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] key
	input  logic                          s_tuser,   // [0] func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bfsh_pkg::M_DATA_W-1:0] m_tdata,   // [0] present, [32:1] insert_count
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfsh_pkg::CFG_W-1:0]    cfg_data   // [10:0] num_words
);

	bfsh_pkg::cmd_t    cmd;
	bfsh_pkg::status_t status;

	// Sequencer
	bfsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Hash, divider, store and result
	bfsh_dpath #(
		.WORDS (WORDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
